@@ rtl/checked_frame_unwrapper_core_defines.svh @@
// Assertion macros for the checked frame unwrapper.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CHECKED_FRAME_UNWRAPPER_CORE_DEFINES_SVH
`define CHECKED_FRAME_UNWRAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define CFU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cfu_pkg.sv @@
// Package for the checked frame unwrapper: transfer types, status codes,
// header layout and FNV-1a helpers. No dependencies.
`timescale 1ns / 1ps
package cfu_pkg;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned POS_W   = 17;

	localparam logic [POS_W-1:0] POS_MAX   = '1;
	localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(12);
	localparam logic [31:0]      FNV_BASIS = 32'd2166136261;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MAGIC   = 3'd1;
	localparam logic [2:0] ST_VERSION = 3'd2;
	localparam logic [2:0] ST_LENGTH  = 3'd3;
	localparam logic [2:0] ST_RECEIPT = 3'd4;
	localparam logic [2:0] ST_BADBYTE = 3'd5;

	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic [2:0]  frame_status;
		logic [15:0] payload_length;
	} result_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [7:0]  format_version;
	} cfg_t;

	// (h ^ b) * 16777619, prime = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
	endfunction

	// tab, LF, CR, printable ASCII
	function automatic logic byte_allowed(input logic [7:0] b);
		return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
			((b >= 8'h20) && (b <= 8'h7E));
	endfunction

endpackage

@@ rtl/cfu_apb_regs.sv @@
// APB register file for the frame unwrapper: magic word and format version.
// Depends on cfu_pkg.
`timescale 1ns / 1ps
module cfu_apb_regs import cfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic        wr_en;
	logic [31:0] magic_q;
	logic [7:0]  version_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			version_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MAGIC:   magic_q   <= pwdata;
				REG_VERSION: version_q <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAGIC:   prdata = magic_q;
			REG_VERSION: prdata = {24'd0, version_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.magic_word     = magic_q;
	assign cfg.format_version = version_q;

endmodule

@@ rtl/checked_frame_unwrapper_core.sv @@
// Checked frame unwrapper top level: input stage, per-frame header/hash state,
// result register. Depends on cfu_pkg, cfu_apb_regs and the assertion macros.
//
//  channel  | signals                           | dir | payload
//  ---------+-----------------------------------+-----+-------------------------
//  item     | item_valid, item_ready            | in  | item (item_t)
//  result   | result_valid, result_ready        | out | result (result_t)
//  config   | psel penable pwrite paddr pwdata  | in  | prdata, pready out
//
// One byte per cycle sustained unless the result stalls.
// The hash update (xor, constant multiply as shift-add) and the status compare
// sit between the input stage and the result register.
// Reset clears frame state to its idle values and both registers to zero.
// A stalled result holds the input stage; a free result register drains it.
`timescale 1ns / 1ps
`include "checked_frame_unwrapper_core_defines.svh"
module checked_frame_unwrapper_core import cfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;

	cfu_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    res_valid_q;
	result_t res_q;

	logic [POS_W-1:0] pos_q,  pos_n;
	logic [31:0]      hash_q, hash_n;
	logic [15:0]      len_q,  len_n;
	logic [31:0]      rcpt_q, rcpt_n;
	logic             magic_bad_q, magic_bad_n;
	logic             ver_bad_q,   ver_bad_n;
	logic             illegal_q,   illegal_n;
	logic             ovf_q,       ovf_n;

	logic [7:0]       b;
	logic             in_payload;
	logic [POS_W-1:0] payload_end;
	logic [POS_W:0]   end_pos;
	logic [POS_W:0]   total_len;
	logic [2:0]       status;
	result_t          res_n;

	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
			item_s1  <= item;
		end
	end

	assign b           = item_s1.frame_byte;
	assign payload_end = HDR_BYTES + {1'b0, len_q};
	assign in_payload  = (pos_q >= HDR_BYTES) && (pos_q < payload_end);

	always_comb begin
		hash_n      = hash_q;
		len_n       = len_q;
		rcpt_n      = rcpt_q;
		magic_bad_n = magic_bad_q;
		ver_bad_n   = ver_bad_q;
		illegal_n   = illegal_q;
		ovf_n       = ovf_q;
		pos_n       = pos_q;
		if (pos_q < POS_W'(4)) begin
			if (b != cfg.magic_word[{~pos_q[1:0], 3'b000} +: 8])
				magic_bad_n = 1'b1;
		end else if (pos_q == POS_W'(4)) begin
			if (b != cfg.format_version)
				ver_bad_n = 1'b1;
		end else if (pos_q == POS_W'(6)) begin
			len_n = {b, len_q[7:0]};
		end else if (pos_q == POS_W'(7)) begin
			len_n = {len_q[15:8], b};
		end else if (pos_q >= POS_W'(8) && pos_q < HDR_BYTES) begin
			rcpt_n = {rcpt_q[23:0], b};
		end else if (in_payload) begin
			hash_n = fnv_mix(hash_q, b);
			if (!byte_allowed(b))
				illegal_n = 1'b1;
		end
		if (pos_q == POS_MAX)
			ovf_n = 1'b1;
		else
			pos_n = pos_q + POS_W'(1);
	end

	assign end_pos   = {1'b0, pos_q} + (POS_W+1)'(1);
	assign total_len = {1'b0, HDR_BYTES} + {2'b00, len_n};

	always_comb begin
		if (end_pos < {1'b0, HDR_BYTES} || magic_bad_n)
			status = ST_MAGIC;
		else if (ver_bad_n)
			status = ST_VERSION;
		else if (ovf_n || end_pos != total_len)
			status = ST_LENGTH;
		else if (hash_n != rcpt_n)
			status = ST_RECEIPT;
		else if (illegal_n)
			status = ST_BADBYTE;
		else
			status = ST_OK;
	end

	always_comb begin
		res_n.payload_valid  = in_payload;
		res_n.payload_byte   = in_payload ? b : 8'd0;
		res_n.frame_done     = item_s1.is_last;
		res_n.frame_status   = item_s1.is_last ? status : ST_OK;
		res_n.payload_length = item_s1.is_last ? len_n : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hash_q      <= FNV_BASIS;
			len_q       <= '0;
			rcpt_q      <= '0;
			magic_bad_q <= 1'b0;
			ver_bad_q   <= 1'b0;
			illegal_q   <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (advance) begin
			if (item_s1.is_last) begin
				pos_q       <= '0;
				hash_q      <= FNV_BASIS;
				len_q       <= '0;
				rcpt_q      <= '0;
				magic_bad_q <= 1'b0;
				ver_bad_q   <= 1'b0;
				illegal_q   <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				pos_q       <= pos_n;
				hash_q      <= hash_n;
				len_q       <= len_n;
				rcpt_q      <= rcpt_n;
				magic_bad_q <= magic_bad_n;
				ver_bad_q   <= ver_bad_n;
				illegal_q   <= illegal_n;
				ovf_q       <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
			res_q       <= res_n;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`CFU_ASSERT_NOW(a_idle_fields_zero, res_valid_q && !res_q.frame_done, res_q.frame_status == ST_OK && res_q.payload_length == 16'd0, "status or length set on a non-final transfer")
	`CFU_ASSERT_NOW(a_payload_byte_zero, res_valid_q && !res_q.payload_valid, res_q.payload_byte == 8'd0, "payload byte set outside payload")
	`CFU_ASSERT_NEXT(a_frame_cleared, advance && item_s1.is_last, pos_q == '0 && hash_q == FNV_BASIS && !ovf_q, "frame state not cleared after last byte")
	`CFU_ASSERT_NOW(a_status_range, res_valid_q, res_q.frame_status <= ST_BADBYTE, "status code out of range")

endmodule
